>>> rtl/core/ser_pkg.sv
// Package for the shared event ring: field widths, item layouts, command codes,
// controller states and the control/status bundles between controller and datapath.
// No dependencies.
package ser_pkg;

    // Item field widths
    localparam int CMD_W    = 2;
    localparam int CLIENT_W = 6;
    localparam int WORD_W   = 32;

    // Stream data widths, padded to whole bytes
    localparam int S_FIELDS_W = CMD_W + CLIENT_W + 3 * WORD_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + 3 * WORD_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    // Defaults for the top level parameters
    localparam int RING_DEPTH_DEF   = 1024;
    localparam int CLIENT_COUNT_DEF = 64;

    // Command codes carried in the input item
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    // Result register update selection
    typedef enum logic [1:0] {
        RES_HOLD,
        RES_ZERO,
        RES_PUSH,
        RES_HIT
    } t_res_op;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_PTR_RD,
        ST_SCAN_LD,
        ST_SCAN,
        ST_RESULT
    } t_state;

    // Ring entry tag: pending mark and destination client
    typedef struct packed {
        logic                valid;
        logic [CLIENT_W-1:0] client;
    } t_meta;

    // Controller to datapath commands
    typedef struct packed {
        logic    cap;
        logic    clr_wr;
        logic    push_rd;
        logic    push_wr;
        logic    scan_ld;
        logic    scan_rd;
        logic    pop_clr;
        t_res_op res_op;
        logic    out_ld;
    } t_ctrl;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic client_ok;
        logic clr_last;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/core/shared_event_ring_with_per_client_scan.sv
// Top level of the shared event ring with per-client scan.
// Depends on ser_pkg, ser_ctrl and ser_dp.
//
// Input channel (s_axis) takes one command item: push an event, pop the next
// event for a client, or check whether a client has an event pending. Output
// channel (m_axis) returns exactly one result item per command item.
// One item is in work at a time; the next is accepted as soon as the previous
// result sits in the output register, even while the receiver stalls it.
// Steps from accept to result valid, after decode:
//   push: tag read, then tag and payload write;
//   pop and check: pointer read, scan load, then a scan of at most RING_DEPTH entries.
//   Unused command codes and out-of-range clients: all-zero result.
// A scan examines one ring entry per cycle through the single tag memory read
// port, starting at the client's read pointer (pop) or at entry 0 (check).
// After reset a clearing pass writes every ring tag as empty; no item
// is accepted during it. The result is held in the output register while the
// receiver stalls; the controller waits for it to free up before returning to idle.
module shared_event_ring_with_per_client_scan #(
    parameter int RING_DEPTH   = ser_pkg::RING_DEPTH_DEF,
    parameter int CLIENT_COUNT = ser_pkg::CLIENT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // cmd[1:0], client_id[7:2], event_code[39:8], first_param[71:40],
    // second_param[103:72]
    input  logic [ser_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // found[0], got_event_code[32:1], got_first_param[64:33],
    // got_second_param[96:65], overwrote[97], zero pad above
    output logic [ser_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import ser_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // Sequencer
    ser_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_ctrl          (ctrl)
    );

    // Ring storage and result path
    ser_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .CLIENT_COUNT (CLIENT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

>>> rtl/core/ser_ctrl.sv
// Controller of the shared event ring: sequences the clearing pass, push,
// pop scan and check scan, and hands results to the output register.
// Depends on ser_pkg.
module ser_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  ser_pkg::t_stat i_stat,
    output ser_pkg::t_ctrl o_ctrl
);
    import ser_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_ctrl          = '0;
        o_ctrl.res_op   = RES_HOLD;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_ctrl.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_ctrl.cap = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_stat.client_ok || i_stat.cmd == CMD_RSVD) begin
                    o_ctrl.res_op = RES_ZERO;
                    n_state       = ST_RESULT;
                end else if (i_stat.cmd == CMD_PUSH) begin
                    n_state = ST_PUSH_RD;
                end else begin
                    n_state = ST_PTR_RD;
                end
            end
            ST_PUSH_RD: begin
                o_ctrl.push_rd = 1'b1;
                n_state        = ST_PUSH_WR;
            end
            ST_PUSH_WR: begin
                o_ctrl.push_wr = 1'b1;
                o_ctrl.res_op  = RES_PUSH;
                n_state        = ST_RESULT;
            end
            ST_PTR_RD: begin
                n_state = ST_SCAN_LD;
            end
            ST_SCAN_LD: begin
                o_ctrl.scan_ld = 1'b1;
                n_state        = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.hit) begin
                    o_ctrl.pop_clr = 1'b1;
                    o_ctrl.res_op  = RES_HIT;
                    n_state        = ST_RESULT;
                end else if (i_stat.last) begin
                    o_ctrl.res_op = RES_ZERO;
                    n_state       = ST_RESULT;
                end else begin
                    o_ctrl.scan_rd = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_ld = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ser_dp.sv
// Datapath of the shared event ring: ring memories, read pointer memory,
// scan address and counter, result and output registers.
// Depends on ser_pkg.
module ser_dp #(
    parameter int RING_DEPTH   = ser_pkg::RING_DEPTH_DEF,
    parameter int CLIENT_COUNT = ser_pkg::CLIENT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ser_pkg::t_ctrl               i_ctrl,
    output ser_pkg::t_stat               o_stat,
    input  logic [ser_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [ser_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import ser_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(CLIENT_COUNT);
    localparam int DW = 3 * WORD_W;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] a);
        f_next = (a == PW'(RING_DEPTH - 1)) ? '0 : a + PW'(1);
    endfunction

    // Memories
    t_meta                meta_mem [RING_DEPTH];
    logic [DW-1:0]        data_mem [RING_DEPTH];
    logic [PW-1:0]        ptr_mem  [CLIENT_COUNT];

    // Captured item
    t_cmd                 r_cmd;
    logic [CLIENT_W-1:0]  r_client;
    logic [DW-1:0]        r_payload;

    // Pointers, scan state
    logic [PW-1:0]        r_wp;
    logic [PW-1:0]        r_addr;
    logic [PW-1:0]        r_chk;
    logic [PW-1:0]        r_rd_addr;
    logic                 r_rd_vld;
    t_meta                r_rd_meta;
    logic [DW-1:0]        r_rd_data;
    logic [CLIENT_COUNT-1:0] r_ptr_vld;
    logic [PW-1:0]        r_ptr_rd;
    logic                 r_ptr_rd_vld;

    // Result and output registers
    logic                 r_res_found;
    logic [DW-1:0]        r_res_data;
    logic                 r_res_ovw;
    logic                 r_out_vld;
    logic                 r_out_found;
    logic [DW-1:0]        r_out_data;
    logic                 r_out_ovw;

    logic [CW-1:0]        cidx;
    logic [PW-1:0]        rd_addr;
    logic                 meta_we;
    logic [PW-1:0]        meta_wa;
    t_meta                meta_wd;
    logic                 is_pop;
    logic                 match;

    assign cidx    = CW'(r_client);
    assign is_pop  = (r_cmd == CMD_POP);
    assign rd_addr = i_ctrl.push_rd ? r_wp : r_addr;
    assign match   = r_rd_meta.valid && (r_rd_meta.client == r_client);

    // Status towards the controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.client_ok = (32'(r_client) < CLIENT_COUNT);
    assign o_stat.clr_last  = (r_addr == PW'(RING_DEPTH - 1));
    assign o_stat.hit       = r_rd_vld && match;
    assign o_stat.last      = r_rd_vld && (r_chk == PW'(RING_DEPTH - 1));
    assign o_stat.out_free  = !r_out_vld || i_m_axis_tready;

    // Tag write port select: clearing pass, push, or pop clearing its hit
    always_comb begin
        meta_we = 1'b0;
        meta_wa = r_addr;
        meta_wd = '0;
        if (i_ctrl.clr_wr) begin
            meta_we = 1'b1;
        end else if (i_ctrl.push_wr) begin
            meta_we        = 1'b1;
            meta_wa        = r_wp;
            meta_wd.valid  = 1'b1;
            meta_wd.client = r_client;
        end else if (i_ctrl.pop_clr && is_pop) begin
            meta_we = 1'b1;
            meta_wa = r_rd_addr;
        end
    end

    // Ring tag memory
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        r_rd_meta <= meta_mem[rd_addr];
    end

    // Ring payload memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push_wr) begin
            data_mem[r_wp] <= r_payload;
        end
        r_rd_data <= data_mem[rd_addr];
    end

    // Read pointer memory, read at the captured client every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pop_clr && is_pop) begin
            ptr_mem[cidx] <= f_next(r_rd_addr);
        end
        r_ptr_rd <= ptr_mem[cidx];
    end

    // Pointer valid bits: an unwritten pointer reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_vld    <= '0;
            r_ptr_rd_vld <= 1'b0;
        end else begin
            if (i_ctrl.pop_clr && is_pop) begin
                r_ptr_vld[cidx] <= 1'b1;
            end
            r_ptr_rd_vld <= r_ptr_vld[cidx];
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_cmd     <= t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
            r_client  <= i_s_axis_tdata[CMD_W +: CLIENT_W];
            r_payload <= i_s_axis_tdata[CMD_W+CLIENT_W +: DW];
        end
    end

    // Write pointer, scan address and read pipeline flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_ctrl.scan_rd;
            if (i_ctrl.push_wr) begin
                r_wp <= f_next(r_wp);
            end
            if (i_ctrl.scan_ld) begin
                r_addr <= (is_pop && r_ptr_rd_vld) ? r_ptr_rd : '0;
            end else if (i_ctrl.scan_rd || i_ctrl.clr_wr) begin
                r_addr <= f_next(r_addr);
            end
        end
    end

    // Address of the tag in the read register and count of entries examined
    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        if (i_ctrl.scan_ld) begin
            r_chk <= '0;
        end else if (r_rd_vld) begin
            r_chk <= r_chk + PW'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        case (i_ctrl.res_op)
            RES_ZERO: begin
                r_res_found <= 1'b0;
                r_res_data  <= '0;
                r_res_ovw   <= 1'b0;
            end
            RES_PUSH: begin
                r_res_found <= 1'b0;
                r_res_data  <= '0;
                r_res_ovw   <= r_rd_meta.valid;
            end
            RES_HIT: begin
                r_res_found <= 1'b1;
                r_res_data  <= is_pop ? r_rd_data : '0;
                r_res_ovw   <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctrl.out_ld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_ld) begin
            r_out_found <= r_res_found;
            r_out_data  <= r_res_data;
            r_out_ovw   <= r_res_ovw;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{M_PAD_W{1'b0}}, r_out_ovw, r_out_data, r_out_found};

endmodule

>>> rtl/core/ser_chk.sv
// Port checker for the shared event ring, bound to the top level.
// Depends on ser_pkg and shared_event_ring_with_per_client_scan.
module ser_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_axis_tvalid,
    input logic                         o_s_axis_tready,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [ser_pkg::M_DATA_W-1:0] o_m_axis_tdata
);
    import ser_pkg::*;

    logic s_acc;
    logic stalled;

    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign stalled = o_m_axis_tvalid && !i_m_axis_tready;

    // One item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input accepted while previous item in work");

    // A result never has found and overwrote both set
    a_found_ovw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1+3*WORD_W]))
        else $error("found and overwrote both set");

    // Nothing found means an all-zero event payload
    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[3*WORD_W:1] == '0))
        else $error("payload present without a found entry");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stalled |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind shared_event_ring_with_per_client_scan ser_chk u_ser_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
